// ===== sv/first_fit_region_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_defines
// Assertion macros used by the allocator controller (ffra_ctrl).
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFRA_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("ffra assertion failed");
`define FFRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffra implication failed");
`else
`define FFRA_ASSERT(lbl, clk, rstn, expr)
`define FFRA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int MAX_RECORDS  = 128;
  localparam int REGION_BYTES = 16384;
  localparam int OFF_W        = 14;
  localparam int SIZE_W       = 15;
  localparam int SUM_W        = SIZE_W + 1;

  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] length;
  } rec_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOGAP = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_MV_RD,
    S_MV_WR,
    S_DONE
  } ctrl_state_e;

endpackage

// ===== sv/ffra_table.sv =====
// ----------------------------------------------------------------------------
// ffra_table
// Record table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffra_table #(
  parameter int MaxRecords = ffra_pkg::MAX_RECORDS,
  localparam int IdxW = $clog2(MaxRecords)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  ffra_pkg::rec_t  wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output ffra_pkg::rec_t  rdata_o
);

  ffra_pkg::rec_t mem [MaxRecords];
  ffra_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: sorted-table scan, shift on insert and remove, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_region_allocator_defines.svh"
module ffra_ctrl #(
  parameter int MaxRecords = ffra_pkg::MAX_RECORDS,
  localparam int IdxW = $clog2(MaxRecords),
  localparam int CntW = $clog2(MaxRecords + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [ffra_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [ffra_pkg::OFF_W-1:0]    free_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffra_pkg::OFF_W-1:0]    block_offset_o,
  output logic                          we_o,
  output logic [IdxW-1:0]               waddr_o,
  output ffra_pkg::rec_t                wdata_o,
  output logic [IdxW-1:0]               raddr_o,
  input  ffra_pkg::rec_t                rdata_i
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxRecords);
  localparam logic [ffra_pkg::SUM_W-1:0] Region = ffra_pkg::SUM_W'(ffra_pkg::REGION_BYTES);

  ffra_pkg::ctrl_state_e state_q, state_d;
  logic                          op_q, op_d;
  logic [ffra_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [ffra_pkg::OFF_W-1:0]    foff_q, foff_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]               mv_q, mv_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [ffra_pkg::SIZE_W-1:0]   pend_q, pend_d;
  logic [ffra_pkg::OFF_W-1:0]    res_off_q, res_off_d;
  ffra_pkg::status_e             res_st_q, res_st_d;
  logic                          ov_q, ov_d;
  logic [ffra_pkg::SUM_W-1:0]    fit_end;
  logic [ffra_pkg::SUM_W-1:0]    rec_end;

  assign fit_end = {1'b0, pend_q} + {1'b0, size_q};
  assign rec_end = {2'b00, rdata_i.start} + {1'b0, rdata_i.length};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffra_pkg::S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    size_q    <= size_d;
    foff_q    <= foff_d;
    idx_q     <= idx_d;
    mv_q      <= mv_d;
    pend_q    <= pend_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    size_d    = size_q;
    foff_d    = foff_q;
    idx_d     = idx_q;
    mv_d      = mv_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    res_off_d = res_off_q;
    res_st_d  = res_st_q;
    ov_d      = ov_q;
    we_o      = 1'b0;
    waddr_o   = mv_q[IdxW-1:0];
    wdata_o   = rdata_i;
    raddr_o   = idx_q[IdxW-1:0];
    // result registers stay untouched until the pending result is taken
    in_ready_o = (state_q == ffra_pkg::S_IDLE) && !ov_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ffra_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d   = opcode_i;
          size_d = req_size_i;
          foff_d = free_offset_i;
          idx_d  = '0;
          pend_d = '0;
          res_off_d = '0;
          state_d = ffra_pkg::S_RD;
          if (opcode_i == ffra_pkg::OP_ALLOC) begin
            if (req_size_i == '0 || {1'b0, req_size_i} > Region) begin
              res_st_d = ffra_pkg::ST_BAD;
              state_d  = ffra_pkg::S_DONE;
            end else if (cnt_q == MaxCnt) begin
              res_st_d = ffra_pkg::ST_FULL;
              state_d  = ffra_pkg::S_DONE;
            end
          end
        end
      end
      ffra_pkg::S_RD: begin
        if (idx_q == cnt_q) begin
          if (op_q == ffra_pkg::OP_ALLOC && fit_end <= Region) begin
            res_off_d = pend_q[ffra_pkg::OFF_W-1:0];
            mv_d      = cnt_q;
            state_d   = ffra_pkg::S_MV_RD;
          end else begin
            res_st_d = (op_q == ffra_pkg::OP_ALLOC) ? ffra_pkg::ST_NOGAP : ffra_pkg::ST_BAD;
            state_d  = ffra_pkg::S_DONE;
          end
        end else begin
          state_d = ffra_pkg::S_EVAL;
        end
      end
      ffra_pkg::S_EVAL: begin
        if (op_q == ffra_pkg::OP_ALLOC) begin
          if (fit_end <= {2'b00, rdata_i.start}) begin
            res_off_d = pend_q[ffra_pkg::OFF_W-1:0];
            mv_d      = cnt_q;
            state_d   = ffra_pkg::S_MV_RD;
          end else begin
            pend_d  = rec_end[ffra_pkg::SIZE_W-1:0];
            idx_d   = idx_q + 1'b1;
            state_d = ffra_pkg::S_RD;
          end
        end else begin
          if (rdata_i.start == foff_q) begin
            res_off_d = foff_q;
            mv_d      = idx_q + 1'b1;
            state_d   = ffra_pkg::S_MV_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ffra_pkg::S_RD;
          end
        end
      end
      ffra_pkg::S_MV_RD: begin
        if (op_q == ffra_pkg::OP_ALLOC) begin
          if (mv_q == idx_q) begin
            we_o     = 1'b1;
            waddr_o  = idx_q[IdxW-1:0];
            wdata_o  = '{start: pend_q[ffra_pkg::OFF_W-1:0], length: size_q};
            cnt_d    = cnt_q + 1'b1;
            res_st_d = ffra_pkg::ST_OK;
            state_d  = ffra_pkg::S_DONE;
          end else begin
            raddr_o = mv_q[IdxW-1:0] - 1'b1;
            state_d = ffra_pkg::S_MV_WR;
          end
        end else begin
          if (mv_q == cnt_q) begin
            cnt_d    = cnt_q - 1'b1;
            res_st_d = ffra_pkg::ST_OK;
            state_d  = ffra_pkg::S_DONE;
          end else begin
            raddr_o = mv_q[IdxW-1:0];
            state_d = ffra_pkg::S_MV_WR;
          end
        end
      end
      ffra_pkg::S_MV_WR: begin
        we_o = 1'b1;
        if (op_q == ffra_pkg::OP_ALLOC) begin
          waddr_o = mv_q[IdxW-1:0];
          mv_d    = mv_q - 1'b1;
        end else begin
          waddr_o = mv_q[IdxW-1:0] - 1'b1;
          mv_d    = mv_q + 1'b1;
        end
        state_d = ffra_pkg::S_MV_RD;
      end
      ffra_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          state_d = ffra_pkg::S_IDLE;
        end
      end
      default: state_d = ffra_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign status_o       = res_st_q;
  assign block_offset_o = (res_st_q == ffra_pkg::ST_OK) ? res_off_q : '0;

  `FFRA_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= MaxCnt)
  `FFRA_ASSERT_IMP(a_we_state, clk_i, rst_ni, we_o,
    state_q == ffra_pkg::S_MV_RD || state_q == ffra_pkg::S_MV_WR)
  `FFRA_ASSERT_IMP(a_cnt_chg, clk_i, rst_ni, cnt_q != $past(cnt_q),
    $past(state_q) == ffra_pkg::S_MV_RD)
  `FFRA_ASSERT_IMP(a_done_out, clk_i, rst_ni,
    state_q == ffra_pkg::S_DONE && (!ov_q || out_ready_i), ##1 ov_q)

endmodule

// ===== sv/first_fit_region_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a fixed byte region with a sorted record table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode_i, req_size_i and
//   free_offset_i; output channel (out_valid_o/out_ready_i) returns status_o
//   and block_offset_o, one result per input transfer.
//   Records are held sorted by start offset in one single-port-read table.
//   One item at a time: the scan reads and evaluates each record visited
//   (S_RD, S_EVAL), and an insert or remove shifts the records above the
//   slot, each with a read and a write (S_MV_RD, S_MV_WR); visited + moved
//   never exceeds MaxRecords. The result then passes through S_DONE into
//   the output register and out_valid_o.
//   in_ready_o is high only while no item is in work and no result waits.
//   A finished result is held in the output register until the receiver
//   takes it; a stalled receiver therefore stalls the input.
//   Reset empties the table at once (count cleared, no clearing pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module first_fit_region_allocator #(
  parameter int MaxRecords = ffra_pkg::MAX_RECORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [ffra_pkg::SIZE_W-1:0] req_size_i,
  input  logic [ffra_pkg::OFF_W-1:0]  free_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [ffra_pkg::OFF_W-1:0]  block_offset_o
);

  localparam int IdxW = $clog2(MaxRecords);

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  ffra_pkg::rec_t  wdata;
  ffra_pkg::rec_t  rdata;

  ffra_ctrl #(.MaxRecords(MaxRecords)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .req_size_i     (req_size_i),
    .free_offset_i  (free_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .block_offset_o (block_offset_o),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  ffra_table #(.MaxRecords(MaxRecords)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
